FILE: hdl/tsle_pkg.sv
// ---------------------------------------------------------------------------
// tsle_pkg
// Shared types and character constants for the text stream formatter.
// ---------------------------------------------------------------------------
package tsle_pkg;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int ESC_MAX    = 4;

   typedef enum logic [2:0] {
      REG_NUMBER_ALL       = 3'd0,
      REG_NUMBER_NONBLANK  = 3'd1,
      REG_SQUEEZE_BLANK    = 3'd2,
      REG_SHOW_NONPRINTING = 3'd3,
      REG_SHOW_ENDS        = 3'd4,
      REG_SHOW_TABS        = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic number_all;
      logic number_nonblank;
      logic squeeze_blank;
      logic show_nonprinting;
      logic show_ends;
      logic show_tabs;
   } cfg_type;

   typedef struct packed {
      logic empty;
      logic finishing;
   } drain_stat_type;

   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_DASH   = 8'h2D;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_QMARK  = 8'h3F;
   localparam logic [7:0] CHAR_I      = 8'h49;
   localparam logic [7:0] CHAR_M      = 8'h4D;
   localparam logic [7:0] CHAR_CARET  = 8'h5E;
   localparam logic [7:0] CHAR_DEL    = 8'h7F;
   localparam logic [7:0] CHAR_FF     = 8'hFF;

   localparam logic [7:0] CTRL_LIMIT     = 8'd32;
   localparam logic [7:0] CTRL_OFFSET    = 8'd64;
   localparam logic [7:0] HIGH_OFFSET    = 8'd128;
   localparam logic [7:0] META_CTRL_LIMIT = 8'd160;

   localparam logic [3:0] BCD_NINE = 4'd9;

endpackage

FILE: hdl/tsle_req_if.sv
// ---------------------------------------------------------------------------
// tsle_req_if
// Input beat channel: one raw text byte and its file start flag.
// ---------------------------------------------------------------------------
interface tsle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       file_start;

   modport source (output valid, output data_byte, output file_start, input ready);
   modport sink   (input valid, input data_byte, input file_start, output ready);
endinterface

FILE: hdl/tsle_rsp_if.sv
// ---------------------------------------------------------------------------
// tsle_rsp_if
// Result beat channel: one formatted byte and the end of run marker.
// ---------------------------------------------------------------------------
interface tsle_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;

   modport source (output valid, output out_byte, output last_of_run, input ready);
   modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

FILE: hdl/text_stream_line_number_escape.sv
// ---------------------------------------------------------------------------
// text_stream_line_number_escape
// Text byte stream formatter: optional line numbers, caret escapes, squeeze.
// ---------------------------------------------------------------------------
// One raw byte enters per req beat and yields zero to NUMBER_DIGITS+5 bytes
// on rsp, the final one marked last_of_run. Bytes that yield at most one
// output byte stream at one per clock while rsp is ready; a byte that yields
// n bytes holds the result register for n rsp beats, since that register
// shifts out one byte per beat, and input is accepted again on the beat of
// its last byte. Bytes pass the input register, then the result register.
// The user sets options through the APB port (registers at byte addresses
// 0,4,...,20) only while idle; the block does not enforce this.
// ---------------------------------------------------------------------------
module text_stream_line_number_escape #(
   parameter int NUMBER_DIGITS = 6
) (
   input  logic                             clock,
   input  logic                             reset,
   tsle_req_if.sink                         req_chan,
   tsle_rsp_if.source                       rsp_chan,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [tsle_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [tsle_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [tsle_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);

   localparam int DEPTH = NUMBER_DIGITS + 1 + tsle_pkg::ESC_MAX;
   localparam int CW    = $clog2(DEPTH + 1);

   tsle_pkg::cfg_type        cfg;
   tsle_pkg::drain_stat_type drain_stat;
   logic                     exp_load;
   logic [DEPTH-1:0][7:0]    exp_bytes;
   logic [CW-1:0]            exp_count;

   tsle_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tsle_format #(
      .NUMBER_DIGITS (NUMBER_DIGITS),
      .DEPTH         (DEPTH),
      .CW            (CW)
   ) u_format (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_chan   (req_chan),
      .drain_stat (drain_stat),
      .exp_load   (exp_load),
      .exp_bytes  (exp_bytes),
      .exp_count  (exp_count)
   );

   tsle_drain #(
      .DEPTH (DEPTH),
      .CW    (CW)
   ) u_drain (
      .clock      (clock),
      .reset      (reset),
      .exp_load   (exp_load),
      .exp_bytes  (exp_bytes),
      .exp_count  (exp_count),
      .drain_stat (drain_stat),
      .rsp_chan   (rsp_chan)
   );

endmodule

FILE: hdl/tsle_csr.sv
// ---------------------------------------------------------------------------
// tsle_csr
// APB-style option registers, one bit each, readable and writable.
// ---------------------------------------------------------------------------
module tsle_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [tsle_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [tsle_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [tsle_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready,
   output tsle_pkg::cfg_type                cfg
);

   tsle_pkg::cfg_type       cfg_ff;
   tsle_pkg::cfg_type       cfg_in;
   tsle_pkg::reg_index_type reg_index;
   logic                    wr_en;
   logic                    rd_bit;

   assign pready    = 1'b1;
   assign wr_en     = psel & penable & pwrite;
   assign reg_index = tsle_pkg::reg_index_type'(paddr[tsle_pkg::CSR_ADDR_W-1:2]);
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      rd_bit = 1'b0;
      case (reg_index)
         tsle_pkg::REG_NUMBER_ALL: begin
            cfg_in.number_all = pwdata[0];
            rd_bit            = cfg_ff.number_all;
         end
         tsle_pkg::REG_NUMBER_NONBLANK: begin
            cfg_in.number_nonblank = pwdata[0];
            rd_bit                 = cfg_ff.number_nonblank;
         end
         tsle_pkg::REG_SQUEEZE_BLANK: begin
            cfg_in.squeeze_blank = pwdata[0];
            rd_bit               = cfg_ff.squeeze_blank;
         end
         tsle_pkg::REG_SHOW_NONPRINTING: begin
            cfg_in.show_nonprinting = pwdata[0];
            rd_bit                  = cfg_ff.show_nonprinting;
         end
         tsle_pkg::REG_SHOW_ENDS: begin
            cfg_in.show_ends = pwdata[0];
            rd_bit           = cfg_ff.show_ends;
         end
         tsle_pkg::REG_SHOW_TABS: begin
            cfg_in.show_tabs = pwdata[0];
            rd_bit           = cfg_ff.show_tabs;
         end
         default: begin
            cfg_in = cfg_ff;
            rd_bit = 1'b0;
         end
      endcase
   end

   assign prdata = {{(tsle_pkg::CSR_DATA_W-1){1'b0}}, rd_bit};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (wr_en) begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: hdl/tsle_format.sv
// ---------------------------------------------------------------------------
// tsle_format
// Input register, line state and the expansion of one byte into its
// line number prefix and escaped character bytes.
// ---------------------------------------------------------------------------
module tsle_format #(
   parameter int NUMBER_DIGITS = 6,
   parameter int DEPTH         = NUMBER_DIGITS + 1 + tsle_pkg::ESC_MAX,
   parameter int CW            = $clog2(DEPTH + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  tsle_pkg::cfg_type         cfg,
   tsle_req_if.sink                  req_chan,
   input  tsle_pkg::drain_stat_type  drain_stat,
   output logic                      exp_load,
   output logic [DEPTH-1:0][7:0]     exp_bytes,
   output logic [CW-1:0]             exp_count
);

   localparam int CNT_W = 4 * NUMBER_DIGITS;

   logic             a_valid_ff;
   logic [7:0]       a_byte_ff;
   logic             a_start_ff;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             ls_ff, ls_in;
   logic             pb_ff, pb_in;
   logic             rs_ff, rs_in;

   logic [CNT_W-1:0] cnt_cur;
   logic [CNT_W-1:0] cnt_inc;
   logic             ls_cur, pb_cur, rs_cur, rs_eff;
   logic             is_lf, squeezed, num_en, char_en, pass_high;
   logic [7:0]       c;
   logic [NUMBER_DIGITS:0][7:0]        nb;
   logic [tsle_pkg::ESC_MAX-1:0][7:0]  chr;
   logic [2:0]       chr_n;
   logic [CW-1:0]    num_len;
   logic             advance;

   assign advance        = a_valid_ff & (drain_stat.empty | drain_stat.finishing);
   assign exp_load       = advance;
   assign req_chan.ready = ~a_valid_ff | advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         a_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready & req_chan.valid) begin
         a_byte_ff  <= req_chan.data_byte;
         a_start_ff <= req_chan.file_start;
      end
   end

   // line state, BCD counter
   always_comb begin
      logic       carry;
      logic       seen;
      logic [3:0] dig;
      cnt_cur = a_start_ff ? CNT_W'(1) : cnt_ff;
      ls_cur  = a_start_ff | ls_ff;
      pb_cur  = ~a_start_ff & pb_ff;
      rs_cur  = ~a_start_ff & rs_ff;
      c       = a_byte_ff;

      carry   = 1'b1;
      cnt_inc = cnt_cur;
      for (int k = 0; k < NUMBER_DIGITS; k++) begin
         dig = cnt_cur[4*k +: 4];
         if (carry) begin
            cnt_inc[4*k +: 4] = (dig == tsle_pkg::BCD_NINE) ? 4'd0 : dig + 4'd1;
         end
         carry = carry & (dig == tsle_pkg::BCD_NINE);
      end
      if (carry) begin
         cnt_inc = cnt_cur;
      end

      seen = 1'b0;
      for (int k = NUMBER_DIGITS - 1; k >= 0; k--) begin
         dig  = cnt_cur[4*k +: 4];
         seen = seen | (dig != 4'd0) | (k == 0);
         nb[NUMBER_DIGITS-1-k] = seen ? (tsle_pkg::CHAR_ZERO + {4'd0, dig})
                                      : tsle_pkg::CHAR_SPACE;
      end
      nb[NUMBER_DIGITS] = tsle_pkg::CHAR_TAB;

      is_lf    = (c == tsle_pkg::CHAR_LF);
      squeezed = ls_cur & is_lf & cfg.squeeze_blank & pb_cur;
      num_en   = 1'b0;
      pb_in    = pb_cur;
      rs_eff   = rs_cur;
      if (ls_cur) begin
         rs_eff = 1'b0;
         if (!squeezed) begin
            pb_in  = is_lf;
            num_en = cfg.number_nonblank ? ~is_lf : cfg.number_all;
         end
      end
      ls_in   = squeezed | is_lf;
      char_en = ~squeezed & ~rs_eff & (c != tsle_pkg::CHAR_NUL);
      rs_in   = ~squeezed & (rs_eff | (c == tsle_pkg::CHAR_NUL));
      cnt_in  = num_en ? cnt_inc : cnt_cur;
   end

   // character escapes
   always_comb begin
      pass_high = cfg.number_all | cfg.number_nonblank | cfg.show_ends |
                  cfg.show_tabs | cfg.squeeze_blank;
      chr   = '0;
      chr_n = 3'd0;
      if (c == tsle_pkg::CHAR_LF) begin
         if (cfg.show_ends) begin
            chr[0] = tsle_pkg::CHAR_DOLLAR;
            chr[1] = tsle_pkg::CHAR_LF;
            chr_n  = 3'd2;
         end else begin
            chr[0] = tsle_pkg::CHAR_LF;
            chr_n  = 3'd1;
         end
      end else if (c == tsle_pkg::CHAR_TAB) begin
         if (cfg.show_tabs) begin
            chr[0] = tsle_pkg::CHAR_CARET;
            chr[1] = tsle_pkg::CHAR_I;
            chr_n  = 3'd2;
         end else begin
            chr[0] = tsle_pkg::CHAR_TAB;
            chr_n  = 3'd1;
         end
      end else if (cfg.show_nonprinting) begin
         if (c < tsle_pkg::CTRL_LIMIT) begin
            chr[0] = tsle_pkg::CHAR_CARET;
            chr[1] = c + tsle_pkg::CTRL_OFFSET;
            chr_n  = 3'd2;
         end else if (c < tsle_pkg::CHAR_DEL) begin
            chr[0] = c;
            chr_n  = 3'd1;
         end else if (c == tsle_pkg::CHAR_DEL) begin
            chr[0] = tsle_pkg::CHAR_CARET;
            chr[1] = tsle_pkg::CHAR_QMARK;
            chr_n  = 3'd2;
         end else begin
            chr[0] = tsle_pkg::CHAR_M;
            chr[1] = tsle_pkg::CHAR_DASH;
            if (c < tsle_pkg::META_CTRL_LIMIT) begin
               chr[2] = tsle_pkg::CHAR_CARET;
               chr[3] = c - tsle_pkg::CTRL_OFFSET;
               chr_n  = 3'd4;
            end else if (c != tsle_pkg::CHAR_FF) begin
               chr[2] = c - tsle_pkg::HIGH_OFFSET;
               chr_n  = 3'd3;
            end else begin
               chr[2] = tsle_pkg::CHAR_CARET;
               chr[3] = tsle_pkg::CHAR_QMARK;
               chr_n  = 3'd4;
            end
         end
      end else if ((c < tsle_pkg::CHAR_DEL) | pass_high) begin
         chr[0] = c;
         chr_n  = 3'd1;
      end
      if (!char_en) begin
         chr_n = 3'd0;
      end
   end

   assign num_len   = num_en ? CW'(NUMBER_DIGITS + 1) : '0;
   assign exp_count = num_len + CW'(chr_n);

   for (genvar j = 0; j < DEPTH; j++) begin : g_pack
      if (j <= NUMBER_DIGITS) begin : g_num
         if (j < tsle_pkg::ESC_MAX) begin : g_both
            assign exp_bytes[j] = num_en ? nb[j] : chr[j];
         end else begin : g_only
            assign exp_bytes[j] = num_en ? nb[j] : tsle_pkg::CHAR_NUL;
         end
      end else begin : g_chr
         if (j < tsle_pkg::ESC_MAX) begin : g_both
            assign exp_bytes[j] = num_en ? chr[j-NUMBER_DIGITS-1] : chr[j];
         end else begin : g_only
            assign exp_bytes[j] = num_en ? chr[j-NUMBER_DIGITS-1] : tsle_pkg::CHAR_NUL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= CNT_W'(1);
         ls_ff  <= 1'b1;
         pb_ff  <= 1'b0;
         rs_ff  <= 1'b0;
      end else if (advance) begin
         cnt_ff <= cnt_in;
         ls_ff  <= ls_in;
         pb_ff  <= pb_in;
         rs_ff  <= rs_in;
      end
   end

endmodule

FILE: hdl/tsle_drain.sv
// ---------------------------------------------------------------------------
// tsle_drain
// Result register: holds one expansion and shifts it out a byte per beat.
// ---------------------------------------------------------------------------
module tsle_drain #(
   parameter int DEPTH = 11,
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      exp_load,
   input  logic [DEPTH-1:0][7:0]     exp_bytes,
   input  logic [CW-1:0]             exp_count,
   output tsle_pkg::drain_stat_type  drain_stat,
   tsle_rsp_if.source                rsp_chan
);

   logic [DEPTH-1:0][7:0] buf_ff;
   logic [CW-1:0]         cnt_ff;
   logic                  beat;

   assign rsp_chan.valid       = (cnt_ff != '0);
   assign rsp_chan.out_byte    = buf_ff[0];
   assign rsp_chan.last_of_run = (cnt_ff == CW'(1));
   assign beat                 = rsp_chan.valid & rsp_chan.ready;

   assign drain_stat.empty     = (cnt_ff == '0);
   assign drain_stat.finishing = beat & rsp_chan.last_of_run;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (exp_load) begin
         cnt_ff <= exp_count;
      end else if (beat) begin
         cnt_ff <= cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (exp_load) begin
         buf_ff <= exp_bytes;
      end else if (beat) begin
         buf_ff <= {8'h00, buf_ff[DEPTH-1:1]};
      end
   end

endmodule

FILE: verif/text_stream_line_number_escape_test.sv
// ---------------------------------------------------------------------------
// text_stream_line_number_escape_test
// Self-checking bench for the text stream formatter. Raw bytes go in on the
// req channel, a line formatter model predicts every rsp beat, and each rsp
// beat is checked in order against it. Options change over APB while idle;
// both channels idle at random, with a long rsp hold-off to back up input.
// ---------------------------------------------------------------------------
module text_stream_line_number_escape_test;

   localparam int NUMBER_DIGITS = 6;
   localparam int DRAIN_CYCLES  = 8;
   localparam int MAX_SHOWN     = 40;
   localparam longint TIMEOUT   = 10_000_000;

   typedef struct {
      logic [7:0] out_byte;
      logic       last_of_run;
   } fmt_beat_type;

   class line_format_scoreboard #(int DIGITS = 6);
      tsle_pkg::cfg_type   cfg;
      logic [4*DIGITS-1:0] line_bcd;
      bit                  at_start;
      bit                  last_blank;
      bit                  suppressed;
      bit                  squeezed;
      logic [7:0]          run_bytes[$];
      fmt_beat_type        expected_beats[$];
      int                  errors;

      function void reset_state();
         cfg        = '0;
         line_bcd   = 1;
         at_start   = 1'b1;
         last_blank = 1'b0;
         suppressed = 1'b0;
         squeezed   = 1'b0;
         errors     = 0;
      endfunction

      function void set_reg(tsle_pkg::reg_index_type idx, logic v);
         case (idx)
            tsle_pkg::REG_NUMBER_ALL:       cfg.number_all       = v;
            tsle_pkg::REG_NUMBER_NONBLANK:  cfg.number_nonblank  = v;
            tsle_pkg::REG_SQUEEZE_BLANK:    cfg.squeeze_blank    = v;
            tsle_pkg::REG_SHOW_NONPRINTING: cfg.show_nonprinting = v;
            tsle_pkg::REG_SHOW_ENDS:        cfg.show_ends        = v;
            tsle_pkg::REG_SHOW_TABS:        cfg.show_tabs        = v;
            default: ;
         endcase
      endfunction

      // right-aligned number, tab, then BCD increment saturating at all nines
      function void emit_number();
         logic [3:0] d;
         bit         seen;
         bit         carried;
         seen = 1'b0;
         for (int i = DIGITS - 1; i >= 0; i--) begin
            d = line_bcd[4*i +: 4];
            if (d != 4'd0 || i == 0) seen = 1'b1;
            run_bytes.push_back(seen ? tsle_pkg::CHAR_ZERO + 8'(d) : tsle_pkg::CHAR_SPACE);
         end
         run_bytes.push_back(tsle_pkg::CHAR_TAB);
         if (line_bcd != {DIGITS{tsle_pkg::BCD_NINE}}) begin
            carried = 1'b1;
            for (int i = 0; i < DIGITS && carried; i++) begin
               d = line_bcd[4*i +: 4];
               if (d == tsle_pkg::BCD_NINE) begin
                  line_bcd[4*i +: 4] = 4'd0;
               end else begin
                  line_bcd[4*i +: 4] = d + 4'd1;
                  carried = 1'b0;
               end
            end
         end
      endfunction

      function void predict_format(logic [7:0] c, logic fs);
         bit           blank;
         bit           pass_high;
         fmt_beat_type b;
         run_bytes.delete();
         if (fs) begin
            line_bcd   = 1;
            at_start   = 1'b1;
            last_blank = 1'b0;
            suppressed = 1'b0;
            squeezed   = 1'b0;
         end
         if (at_start) begin
            blank      = (c == tsle_pkg::CHAR_LF);
            at_start   = 1'b0;
            suppressed = 1'b0;
            if (blank && cfg.squeeze_blank && last_blank) begin
               squeezed = 1'b1;
               at_start = 1'b1;
               return;
            end
            squeezed = 1'b0;
            if (cfg.number_nonblank) begin
               if (!blank) emit_number();
            end else if (cfg.number_all) begin
               emit_number();
            end
            last_blank = blank;
         end
         if (c == tsle_pkg::CHAR_LF) at_start = 1'b1;
         pass_high = cfg.number_all | cfg.number_nonblank | cfg.show_ends |
                     cfg.show_tabs | cfg.squeeze_blank;
         if (!suppressed) begin
            if (c == tsle_pkg::CHAR_NUL) begin
               suppressed = 1'b1;
            end else if (c == tsle_pkg::CHAR_LF) begin
               if (cfg.show_ends) run_bytes.push_back(tsle_pkg::CHAR_DOLLAR);
               run_bytes.push_back(tsle_pkg::CHAR_LF);
            end else if (c == tsle_pkg::CHAR_TAB) begin
               if (cfg.show_tabs) begin
                  run_bytes.push_back(tsle_pkg::CHAR_CARET);
                  run_bytes.push_back(tsle_pkg::CHAR_I);
               end else begin
                  run_bytes.push_back(tsle_pkg::CHAR_TAB);
               end
            end else if (cfg.show_nonprinting) begin
               if (c < tsle_pkg::CTRL_LIMIT) begin
                  run_bytes.push_back(tsle_pkg::CHAR_CARET);
                  run_bytes.push_back(c + tsle_pkg::CTRL_OFFSET);
               end else if (c < tsle_pkg::CHAR_DEL) begin
                  run_bytes.push_back(c);
               end else if (c == tsle_pkg::CHAR_DEL) begin
                  run_bytes.push_back(tsle_pkg::CHAR_CARET);
                  run_bytes.push_back(tsle_pkg::CHAR_QMARK);
               end else begin
                  run_bytes.push_back(tsle_pkg::CHAR_M);
                  run_bytes.push_back(tsle_pkg::CHAR_DASH);
                  if (c < tsle_pkg::META_CTRL_LIMIT) begin
                     run_bytes.push_back(tsle_pkg::CHAR_CARET);
                     run_bytes.push_back(c - tsle_pkg::CTRL_OFFSET);
                  end else if (c < tsle_pkg::CHAR_FF) begin
                     run_bytes.push_back(c - tsle_pkg::HIGH_OFFSET);
                  end else begin
                     run_bytes.push_back(tsle_pkg::CHAR_CARET);
                     run_bytes.push_back(tsle_pkg::CHAR_QMARK);
                  end
               end
            end else if (c < tsle_pkg::CHAR_DEL || pass_high) begin
               run_bytes.push_back(c);
            end
         end
         foreach (run_bytes[k]) begin
            b.out_byte    = run_bytes[k];
            b.last_of_run = (k == run_bytes.size() - 1);
            expected_beats.push_back(b);
         end
      endfunction

      task report(string msg);
         if (errors < MAX_SHOWN) $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_beat(logic [7:0] ob, logic lr);
         fmt_beat_type e;
         if (expected_beats.size() == 0) begin
            report($sformatf("rsp beat out_byte=%02h with nothing expected", ob));
            return;
         end
         e = expected_beats.pop_front();
         if (ob !== e.out_byte)
            report($sformatf("out_byte %02h, expected %02h", ob, e.out_byte));
         if (lr !== e.last_of_run)
            report($sformatf("last_of_run %b, expected %b (out_byte %02h)",
                             lr, e.last_of_run, e.out_byte));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [tsle_pkg::CSR_ADDR_W-1:0] paddr;
   logic [tsle_pkg::CSR_DATA_W-1:0] pwdata;
   logic [tsle_pkg::CSR_DATA_W-1:0] prdata;
   logic pready;

   tsle_req_if req_chan ();
   tsle_rsp_if rsp_chan ();

   line_format_scoreboard #(NUMBER_DIGITS) sb;
   int sent_items  = 0;
   int hold_cycles = 0;
   bit steady      = 1'b0;

   text_stream_line_number_escape #(.NUMBER_DIGITS(NUMBER_DIGITS)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            sb.predict_format(req_chan.data_byte, req_chan.file_start);
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_beat(rsp_chan.out_byte, rsp_chan.last_of_run);
      end
   end

   function automatic int idle_len();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [7:0] text_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 4)  return tsle_pkg::CHAR_NUL;
      if (r < 10) return tsle_pkg::CHAR_TAB;
      if (r < 20) return 8'($urandom_range(1, 31));
      if (r < 32) return 8'($urandom_range(128, 255));
      if (r < 35) return tsle_pkg::CHAR_DEL;
      if (r < 38) return tsle_pkg::CHAR_FF;
      return 8'($urandom_range(32, 126));
   endfunction

   task automatic send_byte(logic [7:0] d, logic fs);
      int n;
      n = idle_len();
      if (n > 0) begin
         req_chan.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.data_byte  <= d;
      req_chan.file_start <= fs;
      do @(posedge clock); while (!req_chan.ready);
      sent_items++;
   endtask

   // mostly well-formed lines, some bursts of raw bytes
   task automatic send_line(int blank_pct, int fs_pct);
      int  len;
      int  r;
      bit  fs;
      fs = ($urandom_range(0, 99) < fs_pct);
      if ($urandom_range(0, 99) < 10) begin
         repeat ($urandom_range(1, 4))
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 99) < 5);
         return;
      end
      r = $urandom_range(0, 99);
      if (r < blank_pct) len = 0;
      else if (r < 85)   len = $urandom_range(1, 4);
      else               len = $urandom_range(5, 12);
      for (int i = 0; i < len; i++) send_byte(text_byte(), fs && i == 0);
      send_byte(tsle_pkg::CHAR_LF, fs && len == 0);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (sb.expected_beats.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(tsle_pkg::reg_index_type idx, logic v);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= tsle_pkg::CSR_ADDR_W'({idx, 2'b00});
      pwdata  <= tsle_pkg::CSR_DATA_W'(v);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_reg(idx, v);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_config(tsle_pkg::cfg_type c);
      csr_write(tsle_pkg::REG_NUMBER_ALL,       c.number_all);
      csr_write(tsle_pkg::REG_NUMBER_NONBLANK,  c.number_nonblank);
      csr_write(tsle_pkg::REG_SQUEEZE_BLANK,    c.squeeze_blank);
      csr_write(tsle_pkg::REG_SHOW_NONPRINTING, c.show_nonprinting);
      csr_write(tsle_pkg::REG_SHOW_ENDS,        c.show_ends);
      csr_write(tsle_pkg::REG_SHOW_TABS,        c.show_tabs);
   endtask

   initial begin : sink_side
      int n;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            n = hold_cycles;
            hold_cycles = 0;
            rsp_chan.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else begin
            n = idle_len();
            if (n > 0) begin
               rsp_chan.ready <= 1'b0;
               repeat (n) @(posedge clock);
            end
         end
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(0, 5)) @(posedge clock);
      end
   end

   initial begin : stimulus
      tsle_pkg::cfg_type c;
      int                target;
      sb = new();
      sb.reset_state();
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.data_byte  <= 8'h00;
      req_chan.file_start <= 1'b0;
      psel                <= 1'b0;
      penable             <= 1'b0;
      pwrite              <= 1'b0;
      paddr               <= '0;
      pwdata              <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // plain pass-through: high bytes dropped, zero byte kills rest of line
      c = '0;
      apply_config(c);
      send_byte(8'h61, 1'b0);
      send_byte(tsle_pkg::CHAR_FF, 1'b0);
      send_byte(tsle_pkg::CHAR_DEL, 1'b0);
      send_byte(tsle_pkg::CHAR_NUL, 1'b0);
      send_byte(8'h62, 1'b0);
      send_byte(tsle_pkg::CHAR_LF, 1'b0);
      drain();

      // numbered, every escape form
      c = '0;
      c.number_all       = 1'b1;
      c.show_nonprinting = 1'b1;
      c.show_ends        = 1'b1;
      c.show_tabs        = 1'b1;
      apply_config(c);
      send_byte(8'h01, 1'b1);
      send_byte(8'h1F, 1'b0);
      send_byte(tsle_pkg::CHAR_DEL, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h9F, 1'b0);
      send_byte(8'hA0, 1'b0);
      send_byte(tsle_pkg::CHAR_FF, 1'b0);
      send_byte(tsle_pkg::CHAR_TAB, 1'b0);
      send_byte(tsle_pkg::CHAR_LF, 1'b0);
      send_byte(8'h85, 1'b0);
      send_byte(tsle_pkg::CHAR_LF, 1'b0);
      drain();

      // nonblank numbering with squeeze; zero-led line is not blank
      c = '0;
      c.number_nonblank = 1'b1;
      c.squeeze_blank   = 1'b1;
      apply_config(c);
      send_byte(tsle_pkg::CHAR_LF, 1'b0);
      send_byte(tsle_pkg::CHAR_LF, 1'b0);
      send_byte(tsle_pkg::CHAR_LF, 1'b0);
      send_byte(tsle_pkg::CHAR_NUL, 1'b0);
      send_byte(tsle_pkg::CHAR_LF, 1'b0);
      send_byte(8'h90, 1'b0);
      send_byte(tsle_pkg::CHAR_LF, 1'b0);
      send_byte(tsle_pkg::CHAR_LF, 1'b0);
      send_byte(tsle_pkg::CHAR_LF, 1'b0);
      send_byte(tsle_pkg::CHAR_LF, 1'b1);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0:       c = '0;
            1:       c = '1;
            default: c = tsle_pkg::cfg_type'(6'($urandom));
         endcase
         // long numbered run to walk the counter through several carries
         if (ph == 5) begin
            c.number_all      = 1'b1;
            c.number_nonblank = 1'b0;
            c.squeeze_blank   = 1'b0;
         end
         apply_config(c);
         steady = (ph == 3);
         if (ph == 2) hold_cycles = 200;
         target = sent_items + ((ph == 5) ? 110 : 55);
         while (sent_items < target)
            send_line((ph == 5) ? 80 : 25, (ph == 5) ? 0 : 3);
         drain();
      end
      steady = 1'b0;

      if (sb.errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT);
      $display("FAILED: results differ");
      $finish;
   end

endmodule
